@@ rtl/drpi_pkg.sv @@
// shared types, constants and tables for the dead reckoning pose integrator
`default_nettype none
package drpi_pkg;

  localparam int POS_WIDTH_DEF      = 48;
  localparam int TRIG_FRAC_BITS_DEF = 15;
  localparam int CORDIC_STEPS       = 24;
  localparam int CNT_W              = 5;
  localparam int PROD_W             = 48;
  localparam logic [31:0] GAIN_RESET   = 32'd68359;
  localparam logic [63:0] CORDIC_K_Q32 = 64'd2608131496;

  typedef struct packed {
    logic        [15:0] elapsed_ticks;
    logic signed [15:0] linear_vel;
    logic signed [15:0] angular_vel;
    logic               clear_path;
    logic               clear_pose;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic        [31:0] heading_angle;
    logic        [47:0] travel_distance;
    logic               headway_tail;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CORDIC,
    ST_SCALE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic prep;
    logic cordic_run;
    logic scale_run;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic cordic_last;
    logic scale_last;
    logic out_free;
  } sts_t;

  // arctangent of 2^-i in 2^-32 turns
  function automatic logic [31:0] atan_turn(input logic [CNT_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/dead_reckoning_pose_integrator.sv @@
// top level of the dead reckoning pose integrator
`default_nettype none
// Each input transaction passes through these steps in order: the item is
// latched, v*t and w*t are formed, 24 iterations of the shared cordic
// sine/cosine run on the committed heading, TRIG_FRAC_BITS + 1 steps of the
// bit-serial multipliers scale v*t by cosine and sine, and the output register
// is loaded, a step that stretches while the previous result still waits for
// out_ready; a new transaction is taken while that result still waits.
// angular_gain is written through the cfg channel, which is ready whenever reset
// is released; write it only while idle.
module dead_reckoning_pose_integrator #(
  parameter int POS_WIDTH      = drpi_pkg::POS_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = drpi_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  drpi_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output drpi_pkg::out_item_t  out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [31:0]          cfg_data
);
  import drpi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = rst_n;

  // sequencer
  drpi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and state
  drpi_datapath #(
    .POS_WIDTH      (POS_WIDTH),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ rtl/drpi_ctrl.sv @@
// sequencing state machine for the pose integrator
`default_nettype none
module drpi_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  drpi_pkg::sts_t    sts,
  output drpi_pkg::cmd_t    cmd
);
  import drpi_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_CORDIC;
      end
      ST_CORDIC: begin
        cmd.cordic_run = 1'b1;
        if (sts.cordic_last) state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale_run = 1'b1;
        if (sts.scale_last) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> !in_ready)
    else $error("input taken while a transaction is in progress");
  a_prep_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> cmd.prep)
    else $error("preparation step missed after accept");
  a_finish_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> in_ready)
    else $error("not idle after finishing a transaction");
`endif

endmodule
`default_nettype wire

@@ rtl/drpi_datapath.sv @@
// pose state, cordic sine/cosine, serial scaling multipliers and output register
`default_nettype none
module drpi_datapath #(
  parameter int POS_WIDTH      = drpi_pkg::POS_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = drpi_pkg::TRIG_FRAC_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  drpi_pkg::cmd_t       cmd,
  output drpi_pkg::sts_t       sts,
  input  drpi_pkg::in_item_t   in_data,
  input  wire                  cfg_valid,
  input  wire  [31:0]          cfg_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output drpi_pkg::out_item_t  out_data
);
  import drpi_pkg::*;

  localparam int F    = TRIG_FRAC_BITS;
  localparam int XW   = F + 3;
  localparam int CW   = F + 2;
  localparam int AW   = PROD_W + F + 1;
  localparam int SUMW = 66;
  localparam int GI_W = $clog2(F + 1);
  localparam logic [63:0] K0_FULL = (CORDIC_K_Q32 + (64'd1 << (31 - F))) >> (32 - F);
  localparam logic signed [XW-1:0] K0 = XW'(K0_FULL);
  localparam logic signed [XW-1:0] ONE = XW'(64'd1 << F);
  localparam logic [AW-1:0] HALF = AW'(64'd1 << (F - 1));
  localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);
  localparam logic [CNT_W-1:0] SCALE_LAST = CNT_W'(F);
  localparam logic signed [SUMW-1:0] PMAX = (SUMW'(1) <<< (POS_WIDTH - 1)) - SUMW'(1);
  localparam logic signed [SUMW-1:0] PMIN = -PMAX - SUMW'(1);

  // architectural state
  logic        [31:0]          gain_r;
  logic signed [15:0]          held_lin_r, held_ang_r;
  logic        [31:0]          time_r;
  logic signed [POS_WIDTH-1:0] posx_r, posy_r;
  logic        [31:0]          head_r;
  logic        [47:0]          dist_r;
  logic                        tail_r;

  // work registers
  in_item_t                    item_r;
  logic                        chg_r;
  logic signed [PROD_W-1:0]    p_r;
  logic        [PROD_W-1:0]    m_r;
  logic        [31:0]          wt_r, hm_r;
  logic signed [XW-1:0]        cx_r, cy_r;
  logic signed [33:0]          cz_r;
  logic        [1:0]           q_r;
  logic        [CNT_W-1:0]     cnt_r;
  logic        [AW-1:0]        accx_r, accy_r;
  out_item_t                   out_r;
  logic                        out_valid_r;

  // saturating time sum
  logic [32:0] tsum;
  assign tsum = {1'b0, time_r} + {17'd0, in_data.elapsed_ticks};

  // prep products
  logic signed [48:0] p_full;
  logic        [63:0] wt_full, hm_full;
  assign p_full  = held_lin_r * $signed({1'b0, time_r});
  assign wt_full = {{16{held_ang_r[15]}}, held_ang_r} * time_r;
  assign hm_full = wt_r * gain_r;

  // quadrant reduction
  logic [31:0] ang_off, rem;
  logic [1:0]  q_new;
  assign ang_off = head_r + 32'h20000000;
  assign q_new   = ang_off[31:30];
  assign rem     = head_r - {q_new, 30'd0};

  // cordic step
  logic signed [XW-1:0] xs, ys;
  logic [33:0]          at;
  assign xs = cx_r >>> cnt_r;
  assign ys = cy_r >>> cnt_r;
  assign at = {2'b00, atan_turn(cnt_r)};

  // clamp and quadrant map
  logic signed [XW-1:0] xcl, ycl;
  logic signed [CW-1:0] xc, yc, cval, sval;
  always_comb begin
    xcl = (cx_r > ONE) ? ONE : ((cx_r < -ONE) ? -ONE : cx_r);
    ycl = (cy_r > ONE) ? ONE : ((cy_r < -ONE) ? -ONE : cy_r);
    xc  = CW'(xcl);
    yc  = CW'(ycl);
    case (q_r)
      2'd0: begin cval = xc;  sval = yc;  end
      2'd1: begin cval = -yc; sval = xc;  end
      2'd2: begin cval = -xc; sval = -yc; end
      default: begin cval = yc; sval = -xc; end
    endcase
  end

  // factor magnitudes and the bit used this scale step
  logic [CW-1:0]      cabs, sabs;
  logic [CNT_W-1:0]   bidx;
  logic               gbx, gby;
  assign cabs = cval[CW-1] ? CW'(-cval) : CW'(cval);
  assign sabs = sval[CW-1] ? CW'(-sval) : CW'(sval);
  assign bidx = SCALE_LAST - cnt_r;
  assign gbx  = cabs[bidx[GI_W-1:0]];
  assign gby  = sabs[bidx[GI_W-1:0]];

  // rounded scaled deltas
  logic [AW-1:0]         rxw, ryw;
  logic signed [49:0]    rx, ry;
  assign rxw = (accx_r + HALF) >> F;
  assign ryw = (accy_r + HALF) >> F;
  assign rx  = (p_r[PROD_W-1] ^ cval[CW-1]) ? -$signed({1'b0, rxw[48:0]})
                                            :  $signed({1'b0, rxw[48:0]});
  assign ry  = (p_r[PROD_W-1] ^ sval[CW-1]) ? -$signed({1'b0, ryw[48:0]})
                                            :  $signed({1'b0, ryw[48:0]});

  // projected pose
  logic signed [SUMW-1:0]      sx, sy;
  logic signed [POS_WIDTH-1:0] prx, pry;
  logic        [31:0]          prh;
  logic        [48:0]          dsum;
  logic        [47:0]          prd;
  always_comb begin
    sx  = SUMW'(posx_r) + SUMW'(rx);
    sy  = SUMW'(posy_r) + SUMW'(ry);
    prx = POS_WIDTH'((sx > PMAX) ? PMAX : ((sx < PMIN) ? PMIN : sx));
    pry = POS_WIDTH'((sy > PMAX) ? PMAX : ((sy < PMIN) ? PMIN : sy));
    prh = hm_r + head_r;
    dsum = {1'b0, dist_r} + {1'b0, m_r};
    prd = dsum[48] ? '1 : dsum[47:0];
  end

  // state after a command change
  logic                        commit, clr;
  logic signed [POS_WIDTH-1:0] nx, ny;
  logic        [31:0]          nh;
  logic        [47:0]          nd;
  logic                        nt;
  always_comb begin
    commit = (held_lin_r != 16'sd0) || (held_ang_r != 16'sd0);
    clr    = item_r.clear_path || item_r.clear_pose;
    nx = commit ? prx : posx_r;
    ny = commit ? pry : posy_r;
    nh = commit ? prh : head_r;
    nd = commit ? prd : dist_r;
    nt = tail_r;
    if (commit && held_lin_r > 16'sd0) nt = 1'b0;
    if (commit && held_lin_r < 16'sd0) nt = 1'b1;
    if (clr) begin
      nd = '0;
      nt = 1'b0;
    end
    if (item_r.clear_pose) begin
      nx = '0;
      ny = '0;
      nh = '0;
    end
  end

  // output formatting
  logic signed [63:0] ox, oy;
  assign ox = 64'(chg_r ? nx : prx);
  assign oy = 64'(chg_r ? ny : pry);

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_RESET;
      held_lin_r  <= '0;
      held_ang_r  <= '0;
      time_r      <= '0;
      posx_r      <= '0;
      posy_r      <= '0;
      head_r      <= '0;
      dist_r      <= '0;
      tail_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) gain_r <= cfg_data;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.accept) time_r <= tsum[32] ? '1 : tsum[31:0];
      if (cmd.prep) cnt_r <= '0;
      if (cmd.cordic_run) cnt_r <= sts.cordic_last ? '0 : cnt_r + CNT_W'(1);
      if (cmd.scale_run) cnt_r <= sts.scale_last ? '0 : cnt_r + CNT_W'(1);
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (chg_r) begin
          posx_r     <= nx;
          posy_r     <= ny;
          head_r     <= nh;
          dist_r     <= nd;
          tail_r     <= nt;
          held_lin_r <= item_r.linear_vel;
          held_ang_r <= item_r.angular_vel;
          time_r     <= '0;
        end
      end
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
      chg_r  <= (in_data.linear_vel != held_lin_r) || (in_data.angular_vel != held_ang_r)
                || in_data.clear_path || in_data.clear_pose;
    end
    if (cmd.prep) begin
      p_r    <= p_full[PROD_W-1:0];
      m_r    <= p_full[48] ? PROD_W'(-p_full) : p_full[PROD_W-1:0];
      wt_r   <= wt_full[31:0];
      q_r    <= q_new;
      cz_r   <= {{2{rem[31]}}, rem};
      cx_r   <= K0;
      cy_r   <= '0;
      accx_r <= '0;
      accy_r <= '0;
    end
    if (cmd.cordic_run) begin
      hm_r <= hm_full[31:0];
      if (!cz_r[33]) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - $signed(at);
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + $signed(at);
      end
    end
    if (cmd.scale_run) begin
      accx_r <= (accx_r << 1) + (gbx ? AW'(m_r) : '0);
      accy_r <= (accy_r << 1) + (gby ? AW'(m_r) : '0);
    end
    if (cmd.finish) begin
      out_r.pos_x           <= ox[47:0];
      out_r.pos_y           <= oy[47:0];
      out_r.heading_angle   <= chg_r ? nh : prh;
      out_r.travel_distance <= chg_r ? nd : prd;
      out_r.headway_tail    <= chg_r ? nt : tail_r;
    end
  end

  assign sts.cordic_last = (cnt_r == CORDIC_LAST);
  assign sts.scale_last  = (cnt_r == SCALE_LAST);
  assign sts.out_free    = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CORDIC_LAST)
    else $error("step counter out of range");
  a_time_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && chg_r) |=> (time_r == 32'd0))
    else $error("elapsed time not restarted after command change");
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("result not presented after finish");
`endif

endmodule
`default_nettype wire
